/* rtl/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// shared constants, codes and state type of the first-fit block allocator
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int POOL_WORDS  = 1024;
	localparam int ALIGN_BYTES = 8;
	localparam int POOL_BYTES  = POOL_WORDS * ALIGN_BYTES;
	localparam int ADDR_W      = $clog2(POOL_WORDS);
	localparam int HDR_W       = 14;
	localparam int LEN_W       = 14;
	localparam int OFF_W       = 13;
	localparam int SUM_W       = LEN_W + 1;
	localparam int TDATA_W     = 32;

	typedef enum logic [1:0] {
		MODE_INIT  = 2'd0,
		MODE_ALLOC = 2'd1,
		MODE_FREE  = 2'd2,
		MODE_OPT   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_NO_FIT   = 2'd1,
		STATUS_BAD_FREE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MG_HEAD,
		ST_MG_HEAD_D,
		ST_MG_NEXT_D,
		ST_MG_WB,
		ST_AL_HEAD,
		ST_AL_HEAD_D,
		ST_AL_SPLIT,
		ST_FR_HEAD,
		ST_FR_HEAD_D,
		ST_FR_CHK_D,
		ST_FR_NEXT_D,
		ST_DONE
	} state_t;

endpackage

/* rtl/ffba_ram.sv */
// ----------------------------------------------------------------------------
// ffba_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ffba_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/first_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// first-fit allocator over a pool of 8-byte words kept as a chain of headers
// ----------------------------------------------------------------------------
// One transaction in gives exactly one transaction out. Block headers live in
// a single ram with a registered read; a header visited at the start of a
// step is first issued as a read and then evaluated, while headers absorbed
// into a free run are read back to back, one per cycle. Init writes the free
// header and posts its result. Allocate and optimize first walk the whole
// chain merging free runs: an allocated block is read and evaluated, a free
// block absorbed into the one before it takes one further read, and a
// surviving free block is read, evaluated and written back, plus one read when
// another block follows it; allocate then walks again up to the first fit,
// with one more write for a split. Each walk ends with an end check and then
// posts the result; free walks up to the given offset and checks its header.
// Input is taken only while no operation is in flight; a finished result sits
// in the output register while the next transaction may already be accepted.
// No clearing pass is needed after reset: only headers on the chain are read.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write: pool_bytes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ffba_pkg::LEN_W-1:0]     cfg_data,
	// input: mode[1:0], request_bytes[15:2], block_offset[28:16]
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ffba_pkg::TDATA_W-1:0]   s_tdata,
	// output: status[1:0], granted_offset[14:2], largest_free[28:15]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ffba_pkg::TDATA_W-1:0]   m_tdata
);

	import ffba_pkg::*;

	state_t             state_q, state_d;
	mode_t              mode_q;
	logic [SUM_W-1:0]   need_q;
	logic [OFF_W-1:0]   off_q;
	logic [LEN_W-1:0]   pos_q;
	logic [LEN_W-1:0]   cur_len_q;
	logic [LEN_W-1:0]   best_q;
	logic [LEN_W-1:0]   rem_q;
	logic [LEN_W-1:0]   pool_len_q;
	logic [LEN_W-1:0]   pool_bytes_q;
	status_t            status_q;
	logic [OFF_W-1:0]   granted_q;
	logic [LEN_W-1:0]   largest_q;
	logic               m_tvalid_q;
	logic [TDATA_W-1:0] m_tdata_q;

	// ram port
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
	logic [HDR_W-1:0]   ram_wdata, ram_rdata;

	// input fields
	logic               in_acc;
	mode_t              in_mode;
	logic [LEN_W-1:0]   in_req;
	logic [OFF_W-1:0]   in_off;

	// header just read and derived sums
	logic               h_free;
	logic [LEN_W-1:0]   h_len;
	logic [SUM_W-1:0]   nx_h;      // pos + length just read
	logic [SUM_W-1:0]   nx_cur;    // pos + merged length so far
	logic [SUM_W-1:0]   nx_cur_h;  // pos + merged length + length just read
	logic               pos_in;
	logic               fit;
	logic [LEN_W-1:0]   fit_rem;
	logic [SUM_W-1:0]   in_need;
	logic [LEN_W-1:0]   init_len;
	logic               out_free;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign in_mode   = mode_t'(s_tdata[1:0]);
	assign in_req    = s_tdata[15:2];
	assign in_off    = s_tdata[28:16];

	assign h_free   = !ram_rdata[0];
	assign h_len    = {ram_rdata[HDR_W-1:1], 1'b0};
	assign nx_h     = {1'b0, pos_q} + {1'b0, h_len};
	assign nx_cur   = {1'b0, pos_q} + {1'b0, cur_len_q};
	assign nx_cur_h = nx_cur + {1'b0, h_len};
	assign pos_in   = pos_q < pool_len_q;
	assign fit      = h_free && ({1'b0, h_len} >= need_q);
	assign fit_rem  = h_len - need_q[LEN_W-1:0];
	assign out_free = !m_tvalid_q || m_tready;

	// request rounded up to the alignment, plus one header word
	assign in_need = (({1'b0, in_req} + SUM_W'(ALIGN_BYTES - 1))
		& ~SUM_W'(ALIGN_BYTES - 1)) + SUM_W'(ALIGN_BYTES);

	// pool length aligned down and capped to the ram size
	assign init_len = (pool_bytes_q >= LEN_W'(POOL_BYTES)) ? LEN_W'(POOL_BYTES)
		: (pool_bytes_q & ~LEN_W'(ALIGN_BYTES - 1));

	ffba_ram #(
		.WIDTH(HDR_W),
		.DEPTH(POOL_WORDS)
	) u_hdr_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (in_mode)
						MODE_INIT:  state_d = ST_DONE;
						MODE_FREE:  state_d = ST_FR_HEAD;
						MODE_ALLOC,
						MODE_OPT:   state_d = ST_MG_HEAD;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_MG_HEAD: begin
				if (!pos_in) begin
					state_d = (mode_q == MODE_ALLOC) ? ST_AL_HEAD : ST_DONE;
				end else begin
					state_d = ST_MG_HEAD_D;
				end
			end
			ST_MG_HEAD_D: begin
				if (!h_free) begin
					state_d = ST_MG_HEAD;
				end else if (nx_h < {1'b0, pool_len_q}) begin
					state_d = ST_MG_NEXT_D;
				end else begin
					state_d = ST_MG_WB;
				end
			end
			ST_MG_NEXT_D: begin
				if (h_free && (nx_cur_h < {1'b0, pool_len_q})) begin
					state_d = ST_MG_NEXT_D;
				end else begin
					state_d = ST_MG_WB;
				end
			end
			ST_MG_WB:     state_d = ST_MG_HEAD;
			ST_AL_HEAD:   state_d = pos_in ? ST_AL_HEAD_D : ST_DONE;
			ST_AL_HEAD_D: begin
				if (!fit) begin
					state_d = ST_AL_HEAD;
				end else if (fit_rem >= LEN_W'(ALIGN_BYTES)) begin
					state_d = ST_AL_SPLIT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_AL_SPLIT:  state_d = ST_DONE;
			ST_FR_HEAD: begin
				if (pos_in && (pos_q < {1'b0, off_q})) begin
					state_d = ST_FR_HEAD_D;
				end else if ((pos_q != {1'b0, off_q}) || !pos_in) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_FR_CHK_D;
				end
			end
			ST_FR_HEAD_D: state_d = ST_FR_HEAD;
			ST_FR_CHK_D: begin
				if (!h_free && (nx_h < {1'b0, pool_len_q})) begin
					state_d = ST_FR_NEXT_D;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_FR_NEXT_D: state_d = ST_DONE;
			ST_DONE:      state_d = out_free ? ST_IDLE : ST_DONE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// ram control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q[ADDR_W+2:3];
		ram_wdata = cur_len_q;
		ram_raddr = pos_q[ADDR_W+2:3];
		unique case (state_q)
			ST_IDLE: begin
				// init writes the single free header at offset zero
				ram_we    = in_acc && (in_mode == MODE_INIT)
					&& (init_len >= LEN_W'(ALIGN_BYTES));
				ram_waddr = '0;
				ram_wdata = init_len;
			end
			ST_MG_HEAD_D: ram_raddr = nx_h[ADDR_W+2:3];
			ST_MG_NEXT_D: ram_raddr = nx_cur_h[ADDR_W+2:3];
			ST_MG_WB:     ram_we = 1'b1;
			ST_AL_HEAD_D: begin
				ram_we    = fit;
				ram_wdata = (fit_rem >= LEN_W'(ALIGN_BYTES))
					? (need_q[LEN_W-1:0] | LEN_W'(1)) : (h_len | LEN_W'(1));
			end
			ST_AL_SPLIT: begin
				ram_we    = 1'b1;
				ram_waddr = nx_cur[ADDR_W+2:3];
				ram_wdata = rem_q;
			end
			ST_FR_CHK_D: begin
				ram_raddr = nx_h[ADDR_W+2:3];
				ram_we    = !h_free && !(nx_h < {1'b0, pool_len_q});
				ram_wdata = h_len;
			end
			ST_FR_NEXT_D: begin
				ram_we    = 1'b1;
				ram_wdata = h_free ? (cur_len_q + h_len) : cur_len_q;
			end
			ST_MG_HEAD, ST_AL_HEAD, ST_FR_HEAD, ST_FR_HEAD_D, ST_DONE: begin
				ram_we = 1'b0;
			end
			default: ram_we = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pool_len_q   <= '0;
			pool_bytes_q <= LEN_W'(POOL_BYTES);
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				pool_bytes_q <= cfg_data;
			end
			if (in_acc && (in_mode == MODE_INIT)) begin
				pool_len_q <= init_len;
			end
			if ((state_q == ST_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				mode_q    <= in_mode;
				need_q    <= in_need;
				off_q     <= in_off;
				pos_q     <= '0;
				best_q    <= '0;
				status_q  <= STATUS_OK;
				granted_q <= '0;
				largest_q <= '0;
			end
			ST_MG_HEAD: begin
				if (!pos_in) begin
					pos_q     <= '0;
					largest_q <= (mode_q == MODE_OPT) ? best_q : '0;
				end
			end
			ST_MG_HEAD_D: begin
				cur_len_q <= h_len;
				if (!h_free) begin
					pos_q <= nx_h[LEN_W-1:0];
				end
			end
			ST_MG_NEXT_D: begin
				if (h_free) begin
					cur_len_q <= cur_len_q + h_len;
				end
			end
			ST_MG_WB: begin
				pos_q <= nx_cur[LEN_W-1:0];
				if ((cur_len_q - LEN_W'(ALIGN_BYTES)) > best_q) begin
					best_q <= cur_len_q - LEN_W'(ALIGN_BYTES);
				end
			end
			ST_AL_HEAD: begin
				if (!pos_in) begin
					status_q <= STATUS_NO_FIT;
				end
			end
			ST_AL_HEAD_D: begin
				if (fit) begin
					granted_q <= pos_q[OFF_W-1:0];
					cur_len_q <= need_q[LEN_W-1:0];
					rem_q     <= fit_rem;
				end else begin
					pos_q <= nx_h[LEN_W-1:0];
				end
			end
			ST_FR_HEAD: begin
				if (!(pos_in && (pos_q < {1'b0, off_q}))
						&& ((pos_q != {1'b0, off_q}) || !pos_in)) begin
					status_q <= STATUS_BAD_FREE;
				end
			end
			ST_FR_HEAD_D: pos_q <= nx_h[LEN_W-1:0];
			ST_FR_CHK_D: begin
				cur_len_q <= h_len;
				if (h_free) begin
					status_q <= STATUS_BAD_FREE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					m_tdata_q <= {3'b000, largest_q, granted_q, status_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

/* rtl/ffba_checker.sv */
// ----------------------------------------------------------------------------
// ffba_props
// port-level checks of the first-fit block allocator, bound to the top level
// ----------------------------------------------------------------------------
module ffba_props (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [ffba_pkg::TDATA_W-1:0] m_tdata
);

	import ffba_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] == STATUS_OK) || (m_tdata[1:0] == STATUS_NO_FIT)
			|| (m_tdata[1:0] == STATUS_BAD_FREE))
		else $error("bad status code");

	// a failed operation reports no grant and no size
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != STATUS_OK) |-> (m_tdata[28:2] == '0))
		else $error("failed transaction carries data");

	// grant offsets are word aligned
	a_grant_align: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[4:2] == 3'b000) && (m_tdata[31:29] == 3'b000))
		else $error("misaligned grant");

endmodule

bind first_fit_block_allocator ffba_props u_ffba_props (.*);
